@@ hdl/dqe_pkg.sv @@
`timescale 1ns / 1ps
// dqe_pkg: shared constants, codes and types of the double-ended queue engine
// depends on nothing; imported by every module of the block except the generic ram
package dqe_pkg;

	localparam int DEPTH     = 64;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int OP_W      = 3;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;

	localparam int IN_BITS   = OP_W + VALUE_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = STATUS_W + VALUE_W + CNT_W + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [ADDR_W:0]  RING_SPAN = (ADDR_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DELETE_ALL = 3'd4,
		OP_REVERSE    = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_DEL_RD,
		S_DEL_CMP,
		S_FINISH
	} state_t;

endpackage

@@ hdl/double_ended_queue_engine.sv @@
`timescale 1ns / 1ps
// double_ended_queue_engine: bounded deque of signed 32-bit values in a ring memory
// push, reverse, clear and a pop on empty pass through the execute and finish states;
// a pop that removes an entry adds a read-wait state between them;
// delete-all adds a read state and a compare-and-move state per entry
// one operation at a time; a new beat is taken in the cycle after the previous result is loaded
// arst_n clears count, front pointer and direction; memory contents stay undefined
module double_ended_queue_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// operation [2:0], value [34:3], zero fill
	input  logic [dqe_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status [1:0], popped_value [33:2], entry_count [40:34], is_empty [41], zero fill
	output logic [dqe_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import dqe_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0]  front_q;
	logic [CNT_W-1:0]   count_q;
	logic               rev_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   kept_q;
	logic               m_tvalid_q;

	op_t                op_q;
	logic [VALUE_W-1:0] val_q;
	status_t            status_q;
	logic [VALUE_W-1:0] popped_q;

	status_t            out_status_q;
	logic [VALUE_W-1:0] out_popped_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_empty_q;

	logic [ADDR_W-1:0]  unit_off;
	logic [ADDR_W-1:0]  unit_addr;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	logic               accept;
	logic               out_free;
	logic               is_full;
	logic               is_zero;
	logic               head_push;
	logic               head_pop;
	logic               keep_entry;
	logic               del_last;
	logic [CNT_W-1:0]   count_m1;

	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign is_full    = (count_q >= CNT_FULL);
	assign is_zero    = (count_q == '0);
	assign head_push  = (op_q == OP_PUSH_FRONT) != rev_q;
	assign head_pop   = (op_q == OP_POP_FRONT) != rev_q;
	assign keep_entry = (ram_rdata != val_q);
	assign del_last   = ((idx_q + CNT_W'(1)) == count_q);
	assign count_m1   = count_q - CNT_W'(1);

	// compaction writes back the entry just read, pushes write the operand
	assign ram_wdata  = (state_q == S_DEL_CMP) ? ram_rdata : val_q;

	dqe_ring_unit u_ring (
		.base   (front_q),
		.offset (unit_off),
		.addr   (unit_addr)
	);

	dqe_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q) inside
					OP_POP_FRONT, OP_POP_BACK: begin
						state_d = is_zero ? S_FINISH : S_POP_WAIT;
					end
					OP_DELETE_ALL: begin
						state_d = is_zero ? S_FINISH : S_DEL_RD;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_POP_WAIT: state_d = S_FINISH;
			S_DEL_RD:   state_d = S_DEL_CMP;
			S_DEL_CMP: begin
				state_d = del_last ? S_FINISH : S_DEL_RD;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: shared adder offset and memory port
	always_comb begin
		unit_off  = '0;
		ram_we    = 1'b0;
		ram_waddr = unit_addr;
		ram_raddr = unit_addr;
		s_tready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_EXEC: begin
				case (op_q) inside
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						unit_off = head_push ? ADDR_W'(DEPTH - 1) : count_q[ADDR_W-1:0];
						ram_we   = !is_full;
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (head_pop) begin
							unit_off  = ADDR_W'(1);
							ram_raddr = front_q;
						end else begin
							unit_off = count_m1[ADDR_W-1:0];
						end
					end
					default: begin
						unit_off = '0;
					end
				endcase
			end
			S_DEL_RD: begin
				unit_off = idx_q[ADDR_W-1:0];
			end
			S_DEL_CMP: begin
				unit_off = kept_q[ADDR_W-1:0];
				ram_we   = keep_entry;
			end
			default: begin
				unit_off = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			rev_q      <= 1'b0;
			idx_q      <= '0;
			kept_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_EXEC: begin
					idx_q  <= '0;
					kept_q <= '0;
					case (op_q) inside
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (!is_full) begin
								count_q <= count_q + CNT_W'(1);
								if (head_push) begin
									front_q <= unit_addr;
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (!is_zero) begin
								count_q <= count_m1;
								if (head_pop) begin
									front_q <= unit_addr;
								end
							end
						end
						OP_REVERSE: begin
							rev_q <= !rev_q;
						end
						OP_CLEAR: begin
							front_q <= '0;
							count_q <= '0;
							rev_q   <= 1'b0;
						end
						default: begin
							rev_q <= rev_q;
						end
					endcase
				end
				S_DEL_CMP: begin
					idx_q <= idx_q + CNT_W'(1);
					if (keep_entry) begin
						kept_q <= kept_q + CNT_W'(1);
					end
					if (del_last) begin
						count_q <= kept_q + CNT_W'(keep_entry);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_tdata[OP_W-1:0]);
			val_q <= s_tdata[OP_W +: VALUE_W];
		end
		if (state_q == S_EXEC) begin
			popped_q <= '0;
			if ((op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK) && is_full) begin
				status_q <= ST_FULL;
			end else if ((op_q == OP_POP_FRONT || op_q == OP_POP_BACK) && is_zero) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (state_q == S_POP_WAIT) begin
			popped_q <= ram_rdata;
		end
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= status_q;
			out_popped_q <= popped_q;
			out_count_q  <= count_q;
			out_empty_q  <= is_zero;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'({out_empty_q, out_count_q, out_popped_q, out_status_q});

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count beyond ring depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, front_q} < RING_SPAN)
		else $error("front pointer outside ring");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_EXEC || state_q == S_DEL_CMP))
		else $error("memory write outside an execute step");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_CMP) |-> (kept_q <= idx_q))
		else $error("compaction write ahead of read pointer");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_empty_q == (out_count_q == '0)))
		else $error("empty flag disagrees with count");

endmodule

@@ hdl/dqe_ram.sv @@
`timescale 1ns / 1ps
// dqe_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module dqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/dqe_ring_unit.sv @@
`timescale 1ns / 1ps
// dqe_ring_unit: shared ring address adder, base plus offset folded into the ring
// depends on dqe_pkg
module dqe_ring_unit (
	input  logic [dqe_pkg::ADDR_W-1:0] base,
	input  logic [dqe_pkg::ADDR_W-1:0] offset,
	output logic [dqe_pkg::ADDR_W-1:0] addr
);
	import dqe_pkg::*;

	logic [ADDR_W:0] sum;

	assign sum  = {1'b0, base} + {1'b0, offset};
	assign addr = (sum >= RING_SPAN) ? ADDR_W'(sum - RING_SPAN) : sum[ADDR_W-1:0];

endmodule
